// File: rtl/core/evs_pkg.sv
`default_nettype none
package evs_pkg;

	localparam int WORLD_HEIGHT_CELLS_DEF = 256;
	localparam int COLUMN_WIDTH_DEF       = 16;
	localparam int RADIUS_CAP_DEF         = 15;

	localparam logic [1:0] CMD_STAMP = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam logic [1:0] REG_COLUMN_X   = 2'd0;
	localparam logic [1:0] REG_COLUMN_Z   = 2'd1;
	localparam logic [1:0] REG_CAVE_FLOOR = 2'd2;

	// signed width of centre-to-column offsets
	localparam int OFFS_W = 40;

	typedef struct packed {
		logic [1:0]         cmd;
		logic signed [31:0] center_x;
		logic signed [31:0] center_y;
		logic signed [31:0] center_z;
		logic [3:0]         radius_h;
		logic [3:0]         radius_v;
		logic [7:0]         read_height;
		logic [3:0]         read_row_z;
	} evs_req_t;

	typedef struct packed {
		logic [15:0] row_bits;
		logic [1:0]  done_cmd;
	} evs_rsp_t;

	function automatic logic [7:0] sq4(input logic [3:0] v);
		logic [7:0] w;
		w = {4'd0, v};
		return w * w;
	endfunction

	function automatic logic [3:0] fix_radius(input logic [3:0] r, input logic [3:0] rmax);
		logic [3:0] v;
		v = (r == 4'd0) ? 4'd1 : r;
		return (v > rmax) ? rmax : v;
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/evs_ram.sv
`default_nettype none
module evs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// File: rtl/core/ellipsoid_voxel_stamp_unit.sv
`default_nettype none
// channel   direction  handshake                  payload
// req       in         req_valid / req_stall      evs_req_t
// rsp       out        rsp_valid / rsp_stall      evs_rsp_t
// apb       in         psel penable pwrite pready column_x, column_z, cave_floor
//
// stamp: setup states SETUP0, SETUP1 and SETUP2, then one mask row per cycle over (2*rv+1)
// heights by COLUMN_WIDTH z rows, plus drain and result; each row reads one mask word and
// writes it back ORed with the hit bits when any lane hits
// read: address, data, then result; clear: one memory word per cycle over all DEPTH words
// after reset a clearing pass of one word per cycle runs before the first request is taken
// a new request is taken while a result waits; a stalled result holds the block in finish
module ellipsoid_voxel_stamp_unit
	import evs_pkg::*;
#(
	parameter int WORLD_HEIGHT_CELLS = WORLD_HEIGHT_CELLS_DEF,
	parameter int COLUMN_WIDTH       = COLUMN_WIDTH_DEF,
	parameter int RADIUS_CAP         = RADIUS_CAP_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire evs_req_t    req,
	output logic             rsp_valid,
	input  wire logic        rsp_stall,
	output evs_rsp_t         rsp,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	localparam int HW    = $clog2(WORLD_HEIGHT_CELLS);
	localparam int ZW    = $clog2(COLUMN_WIDTH);
	localparam int AW    = HW + ZW;
	localparam int DEPTH = 1 << AW;
	localparam logic signed [OFFS_W-1:0] CW_S = OFFS_W'(COLUMN_WIDTH);

	typedef enum logic [3:0] {
		S_IDLE, S_SETUP0, S_SETUP1, S_SETUP2, S_ROW, S_DRAIN,
		S_READ_ADDR, S_READ_DATA, S_CLEAR, S_FINISH
	} state_t;

	state_t state_q;

	logic signed [27:0] column_x_q;
	logic signed [27:0] column_z_q;
	logic [8:0]         cave_floor_q;

	evs_req_t req_q;
	logic [3:0]  rh_q, rv_q;
	logic [7:0]  rh2_q, rv2_q;
	logic [15:0] bound_q;
	logic signed [OFFS_W-1:0] dx0_q, dz0_q;
	logic [3:0]  x_mag_q [COLUMN_WIDTH];
	logic [3:0]  z_mag_q [COLUMN_WIDTH];
	logic        x_ok_q  [COLUMN_WIDTH];
	logic        z_ok_q  [COLUMN_WIDTH];
	logic [15:0] tx_q    [COLUMN_WIDTH];
	logic [15:0] tz_q    [COLUMN_WIDTH];

	logic signed [4:0] dy_q;
	logic [ZW-1:0]     zl_q;
	logic [AW-1:0]     clr_q;
	logic              rpt_q;
	logic [15:0]       res_bits_q;
	logic              rsp_valid_q;
	evs_rsp_t          rsp_q;

	logic              row_v_s1;
	logic [15:0]       ty_s1;
	logic [15:0]       tz_s1;
	logic              y_ok_s1;
	logic              z_ok_s1;
	logic [AW-1:0]     addr_s1;

	logic [3:0]  x_mag_d [COLUMN_WIDTH];
	logic [3:0]  z_mag_d [COLUMN_WIDTH];
	logic        x_ok_d  [COLUMN_WIDTH];
	logic        z_ok_d  [COLUMN_WIDTH];
	logic signed [OFFS_W-1:0] rh_s;
	logic signed [OFFS_W-1:0] dx_l, dz_l;

	logic [3:0]         dy_abs;
	logic signed [33:0] y_sum;
	logic               y_ok;
	logic [AW-1:0]      row_addr;
	logic [AW-1:0]      rd_addr;
	logic               rd_ok;
	logic [17:0]        tyz;
	logic [COLUMN_WIDTH-1:0] hit;

	logic                    ram_we;
	logic [AW-1:0]           ram_waddr;
	logic [COLUMN_WIDTH-1:0] ram_wdata;
	logic [AW-1:0]           ram_raddr;
	logic [COLUMN_WIDTH-1:0] ram_rdata;

	logic accept;
	logic cfg_we;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign pready    = 1'b1;
	assign cfg_we    = psel && penable && pwrite && pready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_x_q   <= '0;
			column_z_q   <= '0;
			cave_floor_q <= '0;
		end else if (cfg_we) begin
			unique case (paddr[3:2])
				REG_COLUMN_X:   column_x_q   <= signed'(pwdata[27:0]);
				REG_COLUMN_Z:   column_z_q   <= signed'(pwdata[27:0]);
				REG_CAVE_FLOOR: cave_floor_q <= pwdata[8:0];
				default:        ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_COLUMN_X:   prdata = 32'(column_x_q);
			REG_COLUMN_Z:   prdata = 32'(column_z_q);
			REG_CAVE_FLOOR: prdata = 32'(cave_floor_q);
			default:        prdata = '0;
		endcase
	end

	// per-lane offsets along x and z
	always_comb begin
		rh_s = signed'(OFFS_W'(rh_q));
		dx_l = '0;
		dz_l = '0;
		for (int l = 0; l < COLUMN_WIDTH; l++) begin
			dx_l = dx0_q + OFFS_W'(l);
			dz_l = dz0_q + OFFS_W'(l);
			x_ok_d[l]  = (dx_l <= rh_s) && (dx_l >= -rh_s);
			z_ok_d[l]  = (dz_l <= rh_s) && (dz_l >= -rh_s);
			x_mag_d[l] = dx_l[OFFS_W-1] ? 4'(-dx_l) : 4'(dx_l);
			z_mag_d[l] = dz_l[OFFS_W-1] ? 4'(-dz_l) : 4'(dz_l);
		end
	end

	// row and read address generation with range checks
	always_comb begin
		dy_abs   = dy_q[4] ? 4'(-dy_q) : 4'(dy_q);
		y_sum    = 34'(req_q.center_y) + 34'(dy_q);
		y_ok     = (y_sum >= signed'(34'(cave_floor_q)))
			&& (y_sum < signed'(34'(WORLD_HEIGHT_CELLS)));
		row_addr = {HW'(y_sum), zl_q};
		rd_addr  = {HW'(req_q.read_height), ZW'(req_q.read_row_z)};
		rd_ok    = (32'(req_q.read_height) < 32'(WORLD_HEIGHT_CELLS))
			&& (32'(req_q.read_row_z) < 32'(COLUMN_WIDTH));
	end

	// inside test on the word just read
	always_comb begin
		tyz = 18'(ty_s1) + 18'(tz_s1);
		for (int l = 0; l < COLUMN_WIDTH; l++) begin
			hit[l] = x_ok_q[l] && y_ok_s1 && z_ok_s1
				&& ((tyz + 18'(tx_q[l])) < 18'(bound_q));
		end
	end

	always_comb begin
		if (state_q == S_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = row_v_s1 && (|hit);
			ram_waddr = addr_s1;
			ram_wdata = ram_rdata | hit;
		end
		ram_raddr = (state_q == S_READ_ADDR) ? rd_addr : row_addr;
	end

	evs_ram #(
		.WIDTH (COLUMN_WIDTH),
		.DEPTH (DEPTH)
	) u_mask_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		unique case (state_q)
			S_SETUP0: begin
				rh_q  <= fix_radius(req_q.radius_h, 4'(RADIUS_CAP));
				rv_q  <= fix_radius(req_q.radius_v, 4'(RADIUS_CAP));
				dx0_q <= OFFS_W'(column_x_q) * CW_S - OFFS_W'(req_q.center_x);
				dz0_q <= OFFS_W'(column_z_q) * CW_S - OFFS_W'(req_q.center_z);
			end
			S_SETUP1: begin
				rh2_q   <= sq4(rh_q);
				rv2_q   <= sq4(rv_q);
				x_mag_q <= x_mag_d;
				z_mag_q <= z_mag_d;
				x_ok_q  <= x_ok_d;
				z_ok_q  <= z_ok_d;
			end
			S_SETUP2: begin
				bound_q <= 16'(rh2_q) * 16'(rv2_q);
				for (int l = 0; l < COLUMN_WIDTH; l++) begin
					tx_q[l] <= 16'(sq4(x_mag_q[l])) * 16'(rv2_q);
					tz_q[l] <= 16'(sq4(z_mag_q[l])) * 16'(rv2_q);
				end
			end
			default: ;
		endcase
		ty_s1   <= 16'(sq4(dy_abs)) * 16'(rh2_q);
		tz_s1   <= tz_q[zl_q];
		z_ok_s1 <= z_ok_q[zl_q];
		y_ok_s1 <= y_ok;
		addr_s1 <= row_addr;
	end

	// control and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			dy_q        <= '0;
			zl_q        <= '0;
			clr_q       <= '0;
			rpt_q       <= 1'b0;
			res_bits_q  <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
			row_v_s1    <= 1'b0;
		end else begin
			row_v_s1 <= (state_q == S_ROW);
			if (rsp_valid_q && !rsp_stall && (state_q != S_FINISH)) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_bits_q <= '0;
						unique case (req.cmd)
							CMD_STAMP: state_q <= S_SETUP0;
							CMD_READ:  state_q <= S_READ_ADDR;
							CMD_CLEAR: begin
								clr_q   <= '0;
								rpt_q   <= 1'b1;
								state_q <= S_CLEAR;
							end
							default:   state_q <= S_FINISH;
						endcase
					end
				end
				S_SETUP0: state_q <= S_SETUP1;
				S_SETUP1: state_q <= S_SETUP2;
				S_SETUP2: begin
					dy_q    <= -signed'(5'(rv_q));
					zl_q    <= '0;
					state_q <= S_ROW;
				end
				S_ROW: begin
					if (32'(zl_q) == COLUMN_WIDTH - 1) begin
						zl_q <= '0;
						if (dy_q == signed'(5'(rv_q))) begin
							state_q <= S_DRAIN;
						end else begin
							dy_q <= dy_q + 5'sd1;
						end
					end else begin
						zl_q <= zl_q + 1'b1;
					end
				end
				S_DRAIN:     state_q <= S_FINISH;
				S_READ_ADDR: state_q <= S_READ_DATA;
				S_READ_DATA: begin
					res_bits_q <= rd_ok ? 16'(ram_rdata) : 16'd0;
					state_q    <= S_FINISH;
				end
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) begin
						state_q <= rpt_q ? S_FINISH : S_IDLE;
						rpt_q   <= 1'b0;
					end
				end
				S_FINISH: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_valid_q    <= 1'b1;
						rsp_q.row_bits <= res_bits_q;
						rsp_q.done_cmd <= req_q.cmd;
						state_q        <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: tb/sv/ellipsoid_voxel_stamp_unit_tb.sv
module ellipsoid_voxel_stamp_unit_tb;
	import evs_pkg::*;

	localparam int HEIGHTS = WORLD_HEIGHT_CELLS_DEF;
	localparam int COL_W = COLUMN_WIDTH_DEF;
	localparam int MAX_R = RADIUS_CAP_DEF;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int COL_MIN = -134217728;
	localparam int COL_MAX = 134217727;
	localparam longint W_MIN = -64'sd2147483648;
	localparam longint W_MAX = 64'sd2147483647;
	localparam int PHASES = 6;
	localparam int PHASE_ITEMS = 180;
	localparam int DRAIN_CYCLES = 600;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	evs_req_t    req = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	evs_rsp_t    rsp;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// shadow copy of the block state
	logic signed [27:0] col_x = '0;
	logic signed [27:0] col_z = '0;
	logic [8:0]         cave_floor = '0;
	logic [COL_W-1:0]   carve_bits [HEIGHTS][COL_W];

	evs_rsp_t pending_rsp [$];
	evs_rsp_t rsp_head;
	int n_fail, n_rsp, n_stamp, n_read, n_clear, n_other, n_settings;
	int burst_left, stall_pct, stall_left, last_y;

	ellipsoid_voxel_stamp_unit DUT (.*);

	always #6 clk = ~clk;

	task automatic clear_carve_bits();
		foreach (carve_bits[h, z]) carve_bits[h][z] = '0;
	endtask

	task automatic carve_ellipsoid(input evs_req_t r);
		longint cx, cy, cz, rh, rv, rh2, rv2, lim, x0, z0, floor_h;
		longint xlo, xhi, zlo, zhi, dx, dy, dz, y, ty, tyz, xl, zl;
		cx = r.center_x;
		cy = r.center_y;
		cz = r.center_z;
		rh = (r.radius_h == 4'd0) ? 1 : r.radius_h;
		rv = (r.radius_v == 4'd0) ? 1 : r.radius_v;
		if (rh > MAX_R) rh = MAX_R;
		if (rv > MAX_R) rv = MAX_R;
		rh2 = rh * rh;
		rv2 = rv * rv;
		lim = rh2 * rv2;
		x0 = longint'(col_x) * COL_W;
		z0 = longint'(col_z) * COL_W;
		floor_h = cave_floor;
		xlo = x0 - cx;
		xhi = x0 + COL_W - 1 - cx;
		zlo = z0 - cz;
		zhi = z0 + COL_W - 1 - cz;
		if (xlo < -rh) xlo = -rh;
		if (xhi > rh) xhi = rh;
		if (zlo < -rh) zlo = -rh;
		if (zhi > rh) zhi = rh;
		if (xlo > xhi || zlo > zhi) return;
		for (dy = -rv; dy <= rv; dy++) begin
			y = cy + dy;
			ty = dy * dy * rh2;
			if (y < floor_h || y >= HEIGHTS || ty >= lim) continue;
			for (dz = zlo; dz <= zhi; dz++) begin
				tyz = ty + dz * dz * rv2;
				zl = cz + dz - z0;
				if (tyz >= lim || zl < 0 || zl >= COL_W) continue;
				for (dx = xlo; dx <= xhi; dx++) begin
					xl = cx + dx - x0;
					if (tyz + dx * dx * rv2 >= lim || xl < 0 || xl >= COL_W) continue;
					carve_bits[y][zl][xl] = 1'b1;
				end
			end
		end
	endtask

	task automatic apply_request(input evs_req_t r, output evs_rsp_t e);
		e.row_bits = '0;
		e.done_cmd = r.cmd;
		case (r.cmd)
		CMD_STAMP: begin
			carve_ellipsoid(r);
			n_stamp++;
		end
		CMD_READ: begin
			e.row_bits = carve_bits[r.read_height][r.read_row_z];
			n_read++;
		end
		CMD_CLEAR: begin
			clear_carve_bits();
			n_clear++;
		end
		default: n_other++;
		endcase
	endtask

	function automatic evs_req_t random_req();
		evs_req_t r;
		r.cmd = 2'($urandom_range(0, 3));
		r.center_x = $urandom;
		r.center_y = $urandom;
		r.center_z = $urandom;
		r.radius_h = 4'($urandom_range(0, 15));
		r.radius_v = 4'($urandom_range(0, 15));
		r.read_height = 8'($urandom_range(0, 255));
		r.read_row_z = 4'($urandom_range(0, 15));
		return r;
	endfunction

	function automatic evs_req_t stamp_req(input longint cx, cy, cz, input int rh, rv);
		evs_req_t r;
		r = random_req();
		r.cmd = CMD_STAMP;
		r.center_x = 32'(cx);
		r.center_y = 32'(cy);
		r.center_z = 32'(cz);
		r.radius_h = 4'(rh);
		r.radius_v = 4'(rv);
		return r;
	endfunction

	function automatic evs_req_t read_req(input int h, z);
		evs_req_t r;
		r = random_req();
		r.cmd = CMD_READ;
		r.read_height = 8'(h);
		r.read_row_z = 4'(z);
		return r;
	endfunction

	function automatic evs_req_t cmd_req(input logic [1:0] c);
		evs_req_t r;
		r = random_req();
		r.cmd = c;
		return r;
	endfunction

	function automatic int rand_col();
		logic signed [27:0] v;
		v = 28'($urandom);
		return int'(v);
	endfunction

	task automatic send_req(input evs_req_t r);
		evs_rsp_t e;
		int gap;
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		apply_request(r, e);
		pending_rsp.push_back(e);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
				: $urandom_range(0, 10);
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 600) : $urandom_range(1, 8);
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		do @(posedge clk); while (pending_rsp.size() != 0);
	endtask

	task automatic apb_access(input logic [1:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
		REG_COLUMN_X: col_x = val[27:0];
		REG_COLUMN_Z: col_z = val[27:0];
		REG_CAVE_FLOOR: cave_floor = val[8:0];
		default: ;
		endcase
	endtask

	task automatic set_config(input int cx, cz, fl);
		apb_access(REG_COLUMN_X, cx);
		apb_access(REG_COLUMN_Z, cz);
		apb_access(REG_CAVE_FLOOR, fl);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		n_settings++;
	endtask

	task automatic test_after_reset();
		evs_req_t r;
		send_req(read_req(0, 0));
		send_req(read_req(HEIGHTS - 1, COL_W - 1));
		r = '1;
		r.cmd = CMD_UNUSED;
		send_req(r);
		wait_drained();
	endtask

	task automatic test_radius_edges();
		send_req(stamp_req(8, 20, 8, 0, 0));
		send_req(read_req(20, 8));
		send_req(stamp_req(8, 128, 8, 15, 15));
		send_req(read_req(113, 8));
		send_req(read_req(114, 8));
		send_req(stamp_req(3, 60, 12, 15, 1));
		send_req(read_req(60, 12));
		wait_drained();
	endtask

	task automatic test_column_clip();
		send_req(stamp_req(-3, 80, 18, 6, 2));
		send_req(read_req(80, 15));
		wait_drained();
		set_config(COL_MIN, COL_MAX, 0);
		send_req(stamp_req(W_MIN, 40, W_MAX, 7, 3));
		send_req(read_req(40, 15));
		send_req(read_req(40, 9));
		send_req(stamp_req(W_MAX, 50, W_MIN, 15, 15));
		send_req(read_req(50, 15));
		wait_drained();
	endtask

	task automatic test_height_band();
		set_config(0, 0, 100);
		send_req(stamp_req(8, 101, 8, 5, 4));
		send_req(read_req(97, 8));
		send_req(read_req(100, 8));
		send_req(stamp_req(8, 253, 8, 4, 6));
		send_req(read_req(255, 8));
		wait_drained();
		set_config(0, 0, 256);
		send_req(stamp_req(8, 30, 8, 9, 9));
		send_req(read_req(30, 8));
		wait_drained();
	endtask

	task automatic test_clear();
		send_req(cmd_req(CMD_CLEAR));
		send_req(read_req(128, 8));
		send_req(read_req(101, 8));
		wait_drained();
	endtask

	task automatic test_random_traffic();
		int pick;
		longint x0, z0;
		evs_req_t r;
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
			0: set_config(0, 0, 0);
			1: set_config(COL_MIN, COL_MAX, $urandom_range(0, 40));
			2: set_config(COL_MAX, COL_MIN, 255);
			3: set_config(rand_col(), rand_col(), 256);
			4: set_config(rand_col(), rand_col(), $urandom_range(0, 120));
			default: set_config(rand_col(), rand_col(), 0);
			endcase
			x0 = longint'(col_x) * COL_W;
			z0 = longint'(col_z) * COL_W;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				pick = $urandom_range(0, 99);
				if (pick < 47) begin
					last_y = int'($urandom_range(0, 300)) - 20;
					r = stamp_req(x0 + int'($urandom_range(0, 47)) - 16, longint'(last_y),
						z0 + int'($urandom_range(0, 47)) - 16,
						$urandom_range(0, MAX_R), $urandom_range(0, MAX_R));
				end else if (pick < 52) begin
					r = cmd_req(CMD_STAMP);
				end else if (pick < 95) begin
					r = read_req($urandom_range(0, 1) ? last_y + int'($urandom_range(0, 30)) - 15
						: int'($urandom_range(0, 255)), $urandom_range(0, 15));
				end else if (pick < 97) begin
					r = cmd_req(CMD_CLEAR);
				end else begin
					r = cmd_req(CMD_UNUSED);
				end
				send_req(r);
				if (ph == 4 && i == PHASE_ITEMS / 2) wait_drained();
			end
			wait_drained();
		end
	endtask

	// response side stalls at a rate of 0, 30, 60 or 90 percent, redrawn when a random countdown runs out
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_pct = $urandom_range(0, 3) * 30;
			stall_left = $urandom_range(10, 300);
		end
		stall_left--;
		rsp_stall <= ($urandom_range(1, 100) <= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				$error("unexpected response: row_bits %h done_cmd %0d", rsp.row_bits, rsp.done_cmd);
				n_fail++;
			end else begin
				rsp_head = pending_rsp.pop_front();
				n_rsp++;
				if (rsp.row_bits !== rsp_head.row_bits) begin
					$error("row_bits mismatch: expected %h, actual %h", rsp_head.row_bits,
						rsp.row_bits);
					n_fail++;
				end
				if (rsp.done_cmd !== rsp_head.done_cmd) begin
					$error("done_cmd mismatch: expected %0d, actual %0d", rsp_head.done_cmd,
						rsp.done_cmd);
					n_fail++;
				end
			end
		end
	end

	initial begin
		clear_carve_bits();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_after_reset();
		test_radius_edges();
		test_column_clip();
		test_height_band();
		test_clear();
		test_random_traffic();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("checked %0d responses: %0d stamps, %0d reads, %0d clears, %0d unused commands",
			n_rsp, n_stamp, n_read, n_clear, n_other);
		$display("column and floor settings applied: %0d, extremes included", n_settings);
		if (n_fail == 0) begin
			$display("ellipsoid_voxel_stamp_unit_tb passed");
		end else begin
			$display("ellipsoid_voxel_stamp_unit_tb failed");
		end
		$finish;
	end

	initial begin
		#48000000;
		$display("ellipsoid_voxel_stamp_unit_tb failed");
		$finish;
	end

endmodule
